>>> rtl/assert_macros.svh
// Assertion macros shared by the hash engine modules.
// Depends on nothing; define NO_ASSERTIONS to drop every check.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, prop, msg)
`define ASSERT_IMPLY(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> rtl/sha2_pkg.sv
// Types, constants and round functions of the SHA-2 hash engine.
// Used by sha2_core, sha2_hash_engine and the testbench; depends on nothing.
package sha2_pkg;

    localparam int DATA_BYTES = 8;

    typedef enum logic [1:0] {
        MODE_256 = 2'd0,
        MODE_384 = 2'd1,
        MODE_512 = 2'd2,
        MODE_RSV = 2'd3
    } hash_mode_t;

    typedef struct packed {
        logic [63:0] message_data;
        logic [3:0]  byte_count;
        logic        end_of_message;
    } in_beat_t;

    typedef struct packed {
        logic [63:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } out_beat_t;

    typedef struct packed {
        logic start;
        logic load_iv;
    } core_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } core_stat_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PAD,
        S_COMP,
        S_OUT
    } eng_state_t;

    typedef enum logic [1:0] {
        C_IDLE,
        C_LOAD,
        C_ROUND,
        C_SUM
    } core_state_t;

    localparam logic [63:0] RK [80] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f,
        64'he9b5dba58189dbbc, 64'h3956c25bf348b538, 64'h59f111f1b605d019,
        64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118, 64'hd807aa98a3030242,
        64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235,
        64'hc19bf174cf692694, 64'he49b69c19ef14ad2, 64'hefbe4786384f25e3,
        64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65, 64'h2de92c6f592b0275,
        64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f,
        64'hbf597fc7beef0ee4, 64'hc6e00bf33da88fc2, 64'hd5a79147930aa725,
        64'h06ca6351e003826f, 64'h142929670a0e6e70, 64'h27b70a8546d22ffc,
        64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6,
        64'h92722c851482353b, 64'ha2bfe8a14cf10364, 64'ha81a664bbc423001,
        64'hc24b8b70d0f89791, 64'hc76c51a30654be30, 64'hd192e819d6ef5218,
        64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99,
        64'h34b0bcb5e19b48a8, 64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb,
        64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3, 64'h748f82ee5defb2fc,
        64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915,
        64'hc67178f2e372532b, 64'hca273eceea26619c, 64'hd186b8c721c0c207,
        64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178, 64'h06f067aa72176fba,
        64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc,
        64'h431d67c49c100d4c, 64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a,
        64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
    };

    localparam logic [63:0] IV512 [8] = '{
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
        64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
        64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
    };

    localparam logic [63:0] IV384 [8] = '{
        64'hcbbb9d5dc1059ed8, 64'h629a292a367cd507, 64'h9159015a3070dd17,
        64'h152fecd8f70e5939, 64'h67332667ffc00b31, 64'h8eb44a8768581511,
        64'hdb0c2e0d64f98fa7, 64'h47b5481dbefa4fa4
    };

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [63:0] ror64(input logic [63:0] x, input int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    function automatic logic [63:0] fit(input logic [63:0] x, input logic m256);
        return m256 ? {32'd0, x[31:0]} : x;
    endfunction

    function automatic logic [63:0] bsig0(input logic [63:0] x, input logic m256);
        return m256 ? {32'd0, ror32(x[31:0], 2) ^ ror32(x[31:0], 13) ^ ror32(x[31:0], 22)}
                    : ror64(x, 28) ^ ror64(x, 34) ^ ror64(x, 39);
    endfunction

    function automatic logic [63:0] bsig1(input logic [63:0] x, input logic m256);
        return m256 ? {32'd0, ror32(x[31:0], 6) ^ ror32(x[31:0], 11) ^ ror32(x[31:0], 25)}
                    : ror64(x, 14) ^ ror64(x, 18) ^ ror64(x, 41);
    endfunction

    function automatic logic [63:0] ssig0(input logic [63:0] x, input logic m256);
        return m256 ? {32'd0, ror32(x[31:0], 7) ^ ror32(x[31:0], 18) ^ (x[31:0] >> 3)}
                    : ror64(x, 1) ^ ror64(x, 8) ^ (x >> 7);
    endfunction

    function automatic logic [63:0] ssig1(input logic [63:0] x, input logic m256);
        return m256 ? {32'd0, ror32(x[31:0], 17) ^ ror32(x[31:0], 19) ^ (x[31:0] >> 10)}
                    : ror64(x, 19) ^ ror64(x, 61) ^ (x >> 6);
    endfunction

    function automatic logic [63:0] init_word(input logic [1:0] mode, input logic [2:0] i);
        logic [63:0] r;
        unique case (mode)
            MODE_256: r = {32'd0, IV512[i][63:32]};
            MODE_384: r = IV384[i];
            default:  r = IV512[i];
        endcase
        return r;
    endfunction

endpackage

>>> rtl/sha2_buf_ram.sv
// Block buffer: 16 x 64-bit synchronous RAM, one write and one read port.
// Read data is registered; depends on nothing.
module sha2_buf_ram (
    input  logic        clk,
    input  logic        we,
    input  logic [3:0]  waddr,
    input  logic [63:0] wdata,
    input  logic [3:0]  raddr,
    output logic [63:0] rdata
);

    logic [63:0] mem [16];
    logic [63:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/sha2_core.sv
// Compression unit: loads a block from the buffer RAM, runs one round per
// cycle and folds the result into the chaining value. Depends on sha2_pkg.
`include "assert_macros.svh"

module sha2_core
    import sha2_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  core_ctrl_t        ctrl,
    input  logic [1:0]        mode,
    output logic [3:0]        raddr,
    input  logic [63:0]       rdata,
    output core_stat_t        stat,
    output logic [7:0][63:0]  cv
);

    core_state_t       cst_reg, cst_next;
    logic [4:0]        lc_reg;
    logic [6:0]        rc_reg;
    logic              half_reg;
    logic [15:0][63:0] w_reg;
    logic [7:0][63:0]  v_reg;
    logic [7:0][63:0]  cv_reg;
    logic              m256;
    logic [6:0]        rc_last;
    logic [63:0]       ld_word, w_new, kt, t1, t2;

    assign m256    = (mode == MODE_256);
    assign rc_last = m256 ? 7'd63 : 7'd79;
    assign raddr   = m256 ? {1'b0, lc_reg[3:1]} : lc_reg[3:0];
    assign ld_word = m256 ? {32'd0, (half_reg ? rdata[31:0] : rdata[63:32])} : rdata;
    assign w_new   = fit(ssig1(w_reg[14], m256) + w_reg[9] + ssig0(w_reg[1], m256)
                         + w_reg[0], m256);
    assign kt      = m256 ? {32'd0, RK[rc_reg][63:32]} : RK[rc_reg];
    assign t1      = v_reg[7] + bsig1(v_reg[4], m256)
                   + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6])) + kt + w_reg[0];
    assign t2      = bsig0(v_reg[0], m256)
                   + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    assign cv      = cv_reg;

    always_comb
    begin
        cst_next = cst_reg;
        unique case (cst_reg)
            C_IDLE:  if (ctrl.start) cst_next = C_LOAD;
            C_LOAD:  if (lc_reg == 5'd16) cst_next = C_ROUND;
            C_ROUND: if (rc_reg == rc_last) cst_next = C_SUM;
            C_SUM:   cst_next = C_IDLE;
            default: cst_next = C_IDLE;
        endcase
    end

    always_comb
    begin
        stat.busy = (cst_reg != C_IDLE);
        stat.done = (cst_reg == C_SUM);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cst_reg <= C_IDLE;
            lc_reg  <= '0;
            rc_reg  <= '0;
            for (int i = 0; i < 8; i++)
            begin
                cv_reg[i] <= init_word(MODE_256, 3'(i));
            end
        end
        else
        begin
            cst_reg <= cst_next;
            unique case (cst_reg)
                C_IDLE:
                begin
                    lc_reg <= '0;
                    rc_reg <= '0;
                    if (ctrl.load_iv)
                    begin
                        for (int i = 0; i < 8; i++)
                        begin
                            cv_reg[i] <= init_word(mode, 3'(i));
                        end
                    end
                end
                C_LOAD:  lc_reg <= lc_reg + 5'd1;
                C_ROUND: rc_reg <= rc_reg + 7'd1;
                C_SUM:
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        cv_reg[i] <= fit(cv_reg[i] + v_reg[i], m256);
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cst_reg)
            C_IDLE:
            begin
                v_reg <= cv_reg;
            end
            C_LOAD:
            begin
                half_reg <= lc_reg[0];
                if (lc_reg != 5'd0)
                begin
                    w_reg <= {ld_word, w_reg[15:1]};
                end
            end
            C_ROUND:
            begin
                w_reg <= {w_new, w_reg[15:1]};
                v_reg <= {v_reg[6:4], fit(v_reg[3] + t1, m256), v_reg[2:0],
                          fit(t1 + t2, m256)};
            end
            default: ;
        endcase
    end

    `ASSERT_ALWAYS(a_rc_range, rc_reg <= 7'd80, "round counter out of range")
    `ASSERT_NEXT(a_done_idle, stat.done, cst_reg == C_IDLE, "core not idle after sum")
    `ASSERT_IMPLY(a_no_restart, ctrl.start, cst_reg == C_IDLE, "start while busy")

endmodule

>>> rtl/sha2_hash_engine.sv
// SHA-2 hash engine top level: byte packing, padding, control and digest out.
// Depends on sha2_pkg, sha2_buf_ram and sha2_core.
//
// An item that neither fills a block nor ends the message leaves the input
// ready for the next. Filling a block starts a compression that stalls the
// input while the core reads the block out of the buffer RAM, runs R rounds
// (R = 64 for SHA-256, 80 for SHA-384/512), one per cycle, and folds in the
// chaining value. The end-of-message item adds the padding words, one or two
// compressions and the digest beats (4, 6 or 8 beats).
`include "assert_macros.svh"

module sha2_hash_engine
    import sha2_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [1:0] cfg_wdata,
    input  logic       in_valid,
    output logic       in_stall,
    input  in_beat_t   in_data,
    output logic       out_valid,
    input  logic       out_stall,
    output out_beat_t  out_data
);

    eng_state_t        state_reg, state_next, ret_reg;
    logic [1:0]        mode_reg;
    logic [3:0]        wcnt_reg;
    logic [2:0]        boff_reg;
    logic [63:0]       part_reg;
    logic [127:0]      len_reg;
    logic              first_reg, here_reg;
    logic [2:0]        widx_reg;

    logic              m256, in_acc, out_acc, full, here_calc, here_eff, wrap;
    logic [3:0]        bw_last, nb, sum;
    logic [2:0]        widx_last;
    logic [63:0]       dmask, pad_word, pad_val;
    logic [127:0]      cat;
    logic              mem_we;
    logic [63:0]       mem_wdata;
    logic [3:0]        raddr;
    logic [63:0]       rdata;
    core_ctrl_t        cctl;
    core_stat_t        cst;
    logic [7:0][63:0]  cv;
    logic              reload;
    logic [1:0]        core_mode;

    assign m256      = (mode_reg == MODE_256);
    assign core_mode = cfg_we ? cfg_wdata : mode_reg;
    assign bw_last   = m256 ? 4'd7 : 4'd15;
    assign widx_last = m256 ? 3'd3 : ((mode_reg == MODE_384) ? 3'd5 : 3'd7);
    assign nb        = (in_data.byte_count > 4'(DATA_BYTES)) ? 4'(DATA_BYTES)
                                                             : in_data.byte_count;
    assign dmask     = in_data.message_data & ~({64{1'b1}} >> {nb, 3'b000});
    assign cat       = {part_reg, 64'd0} | ({dmask, 64'd0} >> {boff_reg, 3'b000});
    assign sum       = {1'b0, boff_reg} + nb;
    assign full      = sum[3];
    assign wrap      = (wcnt_reg == bw_last);
    assign in_acc    = in_valid && !in_stall;
    assign out_acc   = out_valid && !out_stall;
    assign here_calc = wcnt_reg < (m256 ? 4'd7 : 4'd14);
    assign here_eff  = first_reg ? here_calc : here_reg;
    assign pad_word  = part_reg | ({56'd0, 8'h80} << {~boff_reg, 3'b000});
    assign reload    = cfg_we || (out_acc && widx_reg == widx_last);

    always_comb
    begin
        priority if (first_reg)
            pad_val = pad_word;
        else if (here_reg && wrap)
            pad_val = {len_reg[60:0], 3'b000};
        else if (here_reg && !m256 && wcnt_reg == 4'd14)
            pad_val = len_reg[124:61];
        else
            pad_val = '0;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc && full && wrap)
                    state_next = S_COMP;
                else if (in_acc && in_data.end_of_message)
                    state_next = S_PAD;
            end
            S_PAD:  if (wrap) state_next = S_COMP;
            S_COMP: if (cst.done) state_next = ret_reg;
            S_OUT:  if (out_acc && widx_reg == widx_last) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall     = (state_reg != S_IDLE);
        out_valid    = (state_reg == S_OUT);
        mem_we       = 1'b0;
        mem_wdata    = pad_val;
        cctl.start   = 1'b0;
        cctl.load_iv = reload;
        unique case (state_reg)
            S_IDLE:
            begin
                mem_we     = in_acc && full;
                mem_wdata  = cat[127:64];
                cctl.start = in_acc && full && wrap;
            end
            S_PAD:
            begin
                mem_we     = 1'b1;
                cctl.start = wrap;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        out_data.digest_word = m256 ? {cv[{widx_reg[1:0], 1'b0}][31:0],
                                       cv[{widx_reg[1:0], 1'b1}][31:0]}
                                    : cv[widx_reg];
        out_data.word_index  = widx_reg;
        out_data.last_word   = (widx_reg == widx_last);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg   <= S_IDLE;
            mode_reg  <= MODE_256;
            wcnt_reg  <= '0;
            boff_reg  <= '0;
            part_reg  <= '0;
            len_reg   <= '0;
            first_reg <= 1'b0;
            here_reg  <= 1'b0;
            widx_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                mode_reg <= cfg_wdata;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        len_reg   <= len_reg + 128'(nb);
                        boff_reg  <= sum[2:0];
                        first_reg <= 1'b1;
                        ret_reg   <= in_data.end_of_message ? S_PAD : S_IDLE;
                        if (full)
                        begin
                            part_reg <= cat[63:0];
                            wcnt_reg <= wrap ? 4'd0 : wcnt_reg + 4'd1;
                        end
                        else
                        begin
                            part_reg <= cat[127:64];
                        end
                    end
                end
                S_PAD:
                begin
                    first_reg <= 1'b0;
                    boff_reg  <= '0;
                    part_reg  <= '0;
                    here_reg  <= here_eff;
                    wcnt_reg  <= wrap ? 4'd0 : wcnt_reg + 4'd1;
                    if (wrap)
                    begin
                        ret_reg  <= here_eff ? S_OUT : S_PAD;
                        here_reg <= 1'b1;
                    end
                end
                S_OUT:
                begin
                    if (out_acc)
                    begin
                        widx_reg <= widx_reg + 3'd1;
                    end
                end
                default: ;
            endcase
            if (reload)
            begin
                wcnt_reg <= '0;
                boff_reg <= '0;
                part_reg <= '0;
                len_reg  <= '0;
                widx_reg <= '0;
            end
        end
    end

    sha2_buf_ram u_buf (
        .clk   (clk),
        .we    (mem_we),
        .waddr (wcnt_reg),
        .wdata (mem_wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    sha2_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (cctl),
        .mode  (core_mode),
        .raddr (raddr),
        .rdata (rdata),
        .stat  (cst),
        .cv    (cv)
    );

    `ASSERT_IMPLY(a_out_core_idle, out_valid, !cst.busy, "digest beat while compressing")
    `ASSERT_NEXT(a_start_busy, cctl.start, cst.busy, "compression did not start")
    `ASSERT_ALWAYS(a_wcnt_range, wcnt_reg <= bw_last, "buffer word index past block end")

endmodule

>>> tb/sha2_hash_engine_tb.sv
// Self-checking testbench for the SHA-2 hash engine in SHA-256, SHA-384 and SHA-512 modes.
// Depends on sha2_pkg and sha2_hash_engine; it computes the expected digests itself
// and checks every output beat against them, with random gaps on both sides.
`timescale 1ns / 100ps

module sha2_hash_engine_tb;
    import sha2_pkg::*;

    localparam int LATENCY = 400;

    logic      clk;
    logic      rst_n;
    logic      cfg_we;
    logic [1:0] cfg_wdata;
    logic      in_valid;
    logic      in_stall;
    in_beat_t  in_data;
    logic      out_valid;
    logic      out_stall;
    out_beat_t out_data;

    sha2_hash_engine u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    logic [63:0] k_tab [80];
    logic [63:0] iv512_tab [8];
    logic [63:0] iv384_tab [8];

    hash_mode_t  cur_mode;
    logic [63:0] chain [8];
    logic [63:0] blk [16];
    int unsigned fill;
    logic [127:0] msg_len;

    in_beat_t  pending_beats [$];
    out_beat_t digest_q [$];
    int        mismatches;
    int        gap_in;
    int        gap_out;

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [31:0] rr32(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [63:0] rr64(logic [63:0] x, int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    task automatic reload_iv();
        for (int i = 0; i < 8; i++)
        begin
            if (cur_mode == MODE_256)
                chain[i] = {32'd0, iv512_tab[i][63:32]};
            else if (cur_mode == MODE_384)
                chain[i] = iv384_tab[i];
            else
                chain[i] = iv512_tab[i];
        end
        fill = 0;
        msg_len = '0;
    endtask

    task automatic compress_block();
        logic [63:0] w [80];
        logic [63:0] v [8];
        logic [63:0] t1;
        logic [63:0] t2;
        logic [31:0] w32 [64];
        logic [31:0] v32 [8];
        logic [31:0] s1;
        logic [31:0] s2;
        if (cur_mode == MODE_256)
        begin
            for (int i = 0; i < 16; i++)
                w32[i] = (i % 2) ? blk[i / 2][31:0] : blk[i / 2][63:32];
            for (int i = 16; i < 64; i++)
                w32[i] = (rr32(w32[i-2], 17) ^ rr32(w32[i-2], 19) ^ (w32[i-2] >> 10))
                       + w32[i-7]
                       + (rr32(w32[i-15], 7) ^ rr32(w32[i-15], 18) ^ (w32[i-15] >> 3))
                       + w32[i-16];
            for (int i = 0; i < 8; i++)
                v32[i] = chain[i][31:0];
            for (int i = 0; i < 64; i++)
            begin
                s1 = v32[7] + (rr32(v32[4], 6) ^ rr32(v32[4], 11) ^ rr32(v32[4], 25))
                   + ((v32[4] & v32[5]) ^ (~v32[4] & v32[6])) + k_tab[i][63:32] + w32[i];
                s2 = (rr32(v32[0], 2) ^ rr32(v32[0], 13) ^ rr32(v32[0], 22))
                   + ((v32[0] & v32[1]) ^ (v32[0] & v32[2]) ^ (v32[1] & v32[2]));
                v32[7] = v32[6]; v32[6] = v32[5]; v32[5] = v32[4]; v32[4] = v32[3] + s1;
                v32[3] = v32[2]; v32[2] = v32[1]; v32[1] = v32[0]; v32[0] = s1 + s2;
            end
            for (int i = 0; i < 8; i++)
                chain[i] = {32'd0, chain[i][31:0] + v32[i]};
        end
        else
        begin
            for (int i = 0; i < 16; i++)
                w[i] = blk[i];
            for (int i = 16; i < 80; i++)
                w[i] = (rr64(w[i-2], 19) ^ rr64(w[i-2], 61) ^ (w[i-2] >> 6))
                     + w[i-7]
                     + (rr64(w[i-15], 1) ^ rr64(w[i-15], 8) ^ (w[i-15] >> 7))
                     + w[i-16];
            for (int i = 0; i < 8; i++)
                v[i] = chain[i];
            for (int i = 0; i < 80; i++)
            begin
                t1 = v[7] + (rr64(v[4], 14) ^ rr64(v[4], 18) ^ rr64(v[4], 41))
                   + ((v[4] & v[5]) ^ (~v[4] & v[6])) + k_tab[i] + w[i];
                t2 = (rr64(v[0], 28) ^ rr64(v[0], 34) ^ rr64(v[0], 39))
                   + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
                v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
                v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
            end
            for (int i = 0; i < 8; i++)
                chain[i] = chain[i] + v[i];
        end
    endtask

    task automatic push_byte(logic [7:0] b);
        int sh;
        sh = 56 - 8 * (fill % 8);
        blk[fill / 8][sh +: 8] = b;
        fill++;
        if (fill >= ((cur_mode == MODE_256) ? 64 : 128))
        begin
            compress_block();
            fill = 0;
        end
    endtask

    task automatic hash_beat(in_beat_t b);
        int n;
        int lenbytes;
        int nwords;
        logic [127:0] bits;
        out_beat_t o;
        n = (b.byte_count > DATA_BYTES) ? DATA_BYTES : b.byte_count;
        for (int i = 0; i < n; i++)
            push_byte(b.message_data[56 - 8 * i +: 8]);
        msg_len = msg_len + n;
        if (!b.end_of_message)
            return;
        bits = msg_len << 3;
        lenbytes = (cur_mode == MODE_256) ? 8 : 16;
        push_byte(8'h80);
        while (fill != ((cur_mode == MODE_256) ? 64 : 128) - lenbytes)
            push_byte(8'h00);
        for (int i = lenbytes - 1; i >= 0; i--)
            push_byte(bits[8 * i +: 8]);
        nwords = (cur_mode == MODE_256) ? 4 : ((cur_mode == MODE_384) ? 6 : 8);
        for (int i = 0; i < nwords; i++)
        begin
            if (cur_mode == MODE_256)
                o.digest_word = {chain[2 * i][31:0], chain[2 * i + 1][31:0]};
            else
                o.digest_word = chain[i];
            o.word_index = i[2:0];
            o.last_word = (i == nwords - 1);
            digest_q.push_back(o);
        end
        reload_iv();
    endtask

    function automatic in_beat_t rand_beat(logic eom);
        in_beat_t b;
        b.message_data = {$urandom, $urandom};
        b.byte_count = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15)
                                                   : $urandom_range(1, 8);
        b.end_of_message = eom;
        return b;
    endfunction

    function automatic in_beat_t mk_beat(logic [63:0] d, logic [3:0] n, logic eom);
        in_beat_t b;
        b.message_data = d;
        b.byte_count = n;
        b.end_of_message = eom;
        return b;
    endfunction

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // driver: predict at acceptance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data <= '0;
            gap_in = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                hash_beat(in_data);
                void'(pending_beats.pop_front());
                gap_in = gap_len();
            end
            if (!(in_valid && in_stall))
            begin
                if (gap_in > 0 || pending_beats.size() == 0)
                begin
                    if (gap_in > 0)
                        gap_in--;
                    in_valid <= 1'b0;
                end
                else
                begin
                    in_valid <= 1'b1;
                    in_data <= pending_beats[0];
                end
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            gap_out = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (digest_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected beat %h idx %0d last %0b",
                                 out_data.digest_word, out_data.word_index, out_data.last_word);
                end
                else
                begin
                    if (out_data !== digest_q[0])
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch exp %h/%0d/%0b got %h/%0d/%0b",
                                     digest_q[0].digest_word, digest_q[0].word_index,
                                     digest_q[0].last_word, out_data.digest_word,
                                     out_data.word_index, out_data.last_word);
                    end
                    void'(digest_q.pop_front());
                end
            end
            if (gap_out > 0)
            begin
                gap_out--;
                out_stall <= 1'b1;
            end
            else
            begin
                gap_out = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
                out_stall <= (gap_out > 0);
            end
        end
    end

    task automatic drain();
        while (pending_beats.size() != 0 || in_valid || digest_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    task automatic set_mode(hash_mode_t m);
        drain();
        cfg_wdata <= m;
        cfg_we <= 1'b1;
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_mode = m;
        reload_iv();
    endtask

    task automatic queue_message(int nbeats);
        for (int i = 0; i < nbeats; i++)
            pending_beats.push_back(rand_beat(i == nbeats - 1));
    endtask

    initial
    begin
        hash_mode_t mlist [4];
        k_tab = RK;
        iv512_tab = IV512;
        iv384_tab = IV384;
        mismatches = 0;
        cur_mode = MODE_256;
        for (int i = 0; i < 16; i++)
            blk[i] = '0;
        reload_iv();
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        mlist = '{MODE_256, MODE_384, MODE_512, MODE_RSV};
        foreach (mlist[m])
        begin
            set_mode(mlist[m]);
            pending_beats.push_back(mk_beat(64'h0, 4'd0, 1'b1));
            pending_beats.push_back(mk_beat(64'h6162630000000000, 4'd3, 1'b1));
            pending_beats.push_back(mk_beat('1, 4'd15, 1'b0));
            pending_beats.push_back(mk_beat(64'h0, 4'd0, 1'b0));
            pending_beats.push_back(mk_beat(64'h0123456789abcdef, 4'd9, 1'b0));
            for (int i = 0; i < 7; i++)
                pending_beats.push_back(mk_beat({$urandom, $urandom}, 4'd8, 1'b0));
            pending_beats.push_back(mk_beat(64'hffffffffffffffff, 4'd8, 1'b1));
        end
        drain();

        for (int p = 0; p < 5; p++)
        begin
            set_mode(hash_mode_t'($urandom_range(0, 3)));
            for (int k = 0; k < 3; k++)
                queue_message($urandom_range(1, ($urandom_range(0, 4) == 0) ? 20 : 6));
            if ($urandom_range(0, 3) == 0)
                pending_beats.push_back(rand_beat($urandom_range(0, 1)));
        end
        drain();
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("TB_ERROR");
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/sha2_pkg.sv
rtl/sha2_buf_ram.sv
rtl/sha2_core.sv
rtl/sha2_hash_engine.sv
tb/sha2_hash_engine_tb.sv
